FILE: sv/swsc_pkg.sv
// shared types and constants for the streak window sum and sinusoid core
package swsc_pkg;

  localparam int ACC_W      = 32;
  localparam int COEF_W     = 16;
  localparam int HALF_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_BITS  = 14;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_LEN  = 3'd0,
    REG_COS_STEP  = 3'd1,
    REG_SIN_STEP  = 3'd2,
    REG_COS_LEAD  = 3'd3,
    REG_SIN_LEAD  = 3'd4,
    REG_COS_TRAIL = 3'd5,
    REG_SIN_TRAIL = 3'd6
  } cfg_reg_t;

  // register values after reset
  localparam logic [HALF_W-1:0]        HALF_LEN_RST  = 6'd16;
  localparam logic signed [COEF_W-1:0] COS_STEP_RST  = 16'sd13784;
  localparam logic signed [COEF_W-1:0] SIN_STEP_RST  = 16'sd8857;
  localparam logic signed [COEF_W-1:0] COS_LEAD_RST  = -16'sd15721;
  localparam logic signed [COEF_W-1:0] SIN_LEAD_RST  = 16'sd4615;
  localparam logic signed [COEF_W-1:0] COS_TRAIL_RST = -16'sd15721;
  localparam logic signed [COEF_W-1:0] SIN_TRAIL_RST = -16'sd4615;

  // rotation and window weights, Q2.14
  typedef struct packed {
    logic signed [COEF_W-1:0] cos_step;
    logic signed [COEF_W-1:0] sin_step;
    logic signed [COEF_W-1:0] cos_lead;
    logic signed [COEF_W-1:0] sin_lead;
    logic signed [COEF_W-1:0] cos_trail;
    logic signed [COEF_W-1:0] sin_trail;
  } coef_t;

  // running window sums
  typedef struct packed {
    logic signed [ACC_W-1:0] window_sum;
    logic signed [ACC_W-1:0] cos_sum;
    logic signed [ACC_W-1:0] sin_sum;
  } acc_t;

endpackage

FILE: sv/swsc_in_if.sv
// sample input channel
interface swsc_in_if #(
  parameter int SAMPLE_BITS = 20
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          first;
  logic                          emit;

  modport source (output valid, sample, first, emit, input ready);
  modport sink   (input valid, sample, first, emit, output ready);
endinterface

FILE: sv/swsc_out_if.sv
// result output channel
interface swsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] window_sum;
  logic signed [31:0] cos_sum;
  logic signed [31:0] sin_sum;

  modport source (output valid, window_sum, cos_sum, sin_sum, input ready);
  modport sink   (input valid, window_sum, cos_sum, sin_sum, output ready);
endinterface

FILE: sv/swsc_cfg_if.sv
// configuration write channel
interface swsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/swsc_ram.sv
// generic single write port, single read port ram with registered read
module swsc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/swsc_update.sv
// one step of the window sum and rotation recurrence, rounded and saturated
module swsc_update #(
  parameter int SAMPLE_BITS = 20
) (
  input  swsc_pkg::acc_t                acc,
  input  logic                          clear,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] y,
  input  swsc_pkg::coef_t               coef,
  output swsc_pkg::acc_t                acc_next
);
  import swsc_pkg::*;

  localparam int XW  = (SAMPLE_BITS > ACC_W) ? SAMPLE_BITS : ACC_W;
  localparam int PW  = XW + COEF_W + 3;
  localparam int SW  = XW + 2;
  localparam int PCW = ACC_W + COEF_W;
  localparam int XCW = SAMPLE_BITS + COEF_W;
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] P_MAX    = PW'({1'b0, {(ACC_W-1){1'b1}}});
  localparam logic signed [PW-1:0] P_MIN    = -P_MAX - PW'(1);
  localparam logic signed [SW-1:0] S_MAX    = SW'({1'b0, {(ACC_W-1){1'b1}}});
  localparam logic signed [SW-1:0] S_MIN    = -S_MAX - SW'(1);

  logic signed [ACC_W-1:0]              c0, s0, w0;
  logic signed [ACC_W+COEF_W-1:0]       p_cc, p_ss, p_sc, p_cs;
  logic signed [SAMPLE_BITS+COEF_W-1:0] p_xcl, p_ycl, p_xsl, p_yst;
  logic signed [PW-1:0]                 cos_tot, sin_tot, cos_rnd, sin_rnd;
  logic signed [SW-1:0]                 win_tot;

  // a new trajectory starts from zero sums
  assign c0 = clear ? '0 : acc.cos_sum;
  assign s0 = clear ? '0 : acc.sin_sum;
  assign w0 = clear ? '0 : acc.window_sum;

  // rotation products and entering/leaving weights
  assign p_cc  = PCW'(c0) * PCW'(coef.cos_step);
  assign p_ss  = PCW'(s0) * PCW'(coef.sin_step);
  assign p_sc  = PCW'(s0) * PCW'(coef.cos_step);
  assign p_cs  = PCW'(c0) * PCW'(coef.sin_step);
  assign p_xcl = XCW'(x) * XCW'(coef.cos_lead);
  assign p_ycl = XCW'(y) * XCW'(coef.cos_trail);
  assign p_xsl = XCW'(x) * XCW'(coef.sin_lead);
  assign p_yst = XCW'(y) * XCW'(coef.sin_trail);

  assign cos_tot = PW'(p_cc) + PW'(p_ss) + PW'(p_xcl) - PW'(p_ycl);
  assign sin_tot = PW'(p_sc) - PW'(p_cs) + PW'(p_xsl) + PW'(p_yst);

  // round half up back to Q.0, dropping the 14 fraction bits
  assign cos_rnd = (cos_tot + RND_HALF) >>> FRAC_BITS;
  assign sin_rnd = (sin_tot + RND_HALF) >>> FRAC_BITS;

  assign win_tot = SW'(w0) + SW'(x) - SW'(y);

  // saturate to 32 bits
  always_comb begin
    if (cos_rnd > P_MAX) begin
      acc_next.cos_sum = P_MAX[ACC_W-1:0];
    end else if (cos_rnd < P_MIN) begin
      acc_next.cos_sum = P_MIN[ACC_W-1:0];
    end else begin
      acc_next.cos_sum = cos_rnd[ACC_W-1:0];
    end

    if (sin_rnd > P_MAX) begin
      acc_next.sin_sum = P_MAX[ACC_W-1:0];
    end else if (sin_rnd < P_MIN) begin
      acc_next.sin_sum = P_MIN[ACC_W-1:0];
    end else begin
      acc_next.sin_sum = sin_rnd[ACC_W-1:0];
    end

    if (win_tot > S_MAX) begin
      acc_next.window_sum = S_MAX[ACC_W-1:0];
    end else if (win_tot < S_MIN) begin
      acc_next.window_sum = S_MIN[ACC_W-1:0];
    end else begin
      acc_next.window_sum = win_tot[ACC_W-1:0];
    end
  end

endmodule

FILE: sv/streak_window_sum_and_sinusoid_core.sv
// streak window sum and sinusoid core: sliding dft bin with a moving tophat sum
// path: an accepted sample beat is registered in stage 1, and its sums load the output register when stage 1 advances
// throughput: one sample per cycle while the result side does not stall stage 1, set by the combinational
//   accumulator recurrence and the one delay ram read issued with each accepted beat
// reset: sums, fill count, delay pointer and pipeline flags clear, registers take defaults
// the delay ram is not cleared; entries are only used once the fill count covers them
module streak_window_sum_and_sinusoid_core #(
  parameter int MAX_HALF_LEN = 63,
  parameter int SAMPLE_BITS  = 20
) (
  input  logic              clk,
  input  logic              rst,
  swsc_cfg_if.sink          cfg,
  swsc_in_if.sink           samples,
  swsc_out_if.source        results
);
  import swsc_pkg::*;

  localparam int DEPTH = 2 * MAX_HALF_LEN + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = (AW > HALF_W) ? AW : HALF_W;
  localparam logic [LW-1:0] L_MAX    = LW'(MAX_HALF_LEN);
  localparam logic [AW-1:0] FILL_MAX = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X  = (AW+1)'(DEPTH);

  // configuration registers
  logic [HALF_W-1:0] half_len;
  coef_t             coef;

  // delay line pointer and fill
  logic [AW-1:0] wp, wp_next;
  logic [AW-1:0] fill, fill_next;

  // stage 1, waiting for the delay ram read
  logic                          s1_valid;
  logic                          s1_first;
  logic                          s1_emit;
  logic                          s1_use_y;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic                          s1_adv;

  acc_t acc, acc_next;
  acc_t out_q;
  logic out_valid;

  logic                          in_acc;
  logic [LW-1:0]                 l_ext, l_sat;
  logic [AW-1:0]                 span;
  logic [AW:0]                   rd_wide;
  logic [AW-1:0]                 rd_addr;
  logic                          use_y;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic signed [SAMPLE_BITS-1:0] y;

  // configuration writes, unknown indexes ignored
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_len       <= HALF_LEN_RST;
      coef.cos_step  <= COS_STEP_RST;
      coef.sin_step  <= SIN_STEP_RST;
      coef.cos_lead  <= COS_LEAD_RST;
      coef.sin_lead  <= SIN_LEAD_RST;
      coef.cos_trail <= COS_TRAIL_RST;
      coef.sin_trail <= SIN_TRAIL_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HALF_LEN:  half_len       <= cfg.data[HALF_W-1:0];
        REG_COS_STEP:  coef.cos_step  <= cfg.data;
        REG_SIN_STEP:  coef.sin_step  <= cfg.data;
        REG_COS_LEAD:  coef.cos_lead  <= cfg.data;
        REG_SIN_LEAD:  coef.sin_lead  <= cfg.data;
        REG_COS_TRAIL: coef.cos_trail <= cfg.data;
        REG_SIN_TRAIL: coef.sin_trail <= cfg.data;
        default: ;
      endcase
    end
  end

  // handshake: stage 1 moves on when its result has room or it emits nothing
  assign s1_adv        = s1_valid && (!s1_emit || !out_valid || results.ready);
  assign samples.ready = !s1_valid || s1_adv;
  assign in_acc        = samples.valid && samples.ready;

  // window span and address of the leaving sample
  assign l_ext   = LW'(half_len);
  assign l_sat   = (l_ext > L_MAX) ? L_MAX : l_ext;
  assign span    = AW'({l_sat, 1'b1});
  assign rd_wide = ({1'b0, wp} >= {1'b0, span}) ? ({1'b0, wp} - {1'b0, span})
                                                : ({1'b0, wp} + DEPTH_X - {1'b0, span});
  assign rd_addr = rd_wide[AW-1:0];
  assign use_y   = !samples.first && (fill >= span);

  // pointer wraps at the ram depth, fill saturates one below it
  always_comb begin
    wp_next = (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
    if (samples.first) begin
      fill_next = AW'(1);
    end else if (fill < FILL_MAX) begin
      fill_next = fill + AW'(1);
    end else begin
      fill_next = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (in_acc) begin
      wp   <= wp_next;
      fill <= fill_next;
    end
  end

  // delay line, written and read with each accepted beat
  swsc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_delay (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp),
    .wdata (samples.sample),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_first <= samples.first;
      s1_emit  <= samples.emit;
      s1_use_y <= use_y;
      s1_x     <= samples.sample;
    end
  end

  assign y = s1_use_y ? $signed(rd_data) : '0;

  // accumulator update
  swsc_update #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_update (
    .acc      (acc),
    .clear    (s1_first),
    .x        (s1_x),
    .y        (y),
    .coef     (coef),
    .acc_next (acc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s1_adv) begin
      acc <= acc_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_q <= acc_next;
    end
  end

  assign results.valid      = out_valid;
  assign results.window_sum = out_q.window_sum;
  assign results.cos_sum    = out_q.cos_sum;
  assign results.sin_sum    = out_q.sin_sum;

  // a stalled stage 1 keeps its beat
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("stage 1 beat dropped while stalled");

  // no beat is accepted into a blocked stage 1
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> (!s1_valid || s1_adv))
    else $error("input beat accepted over a stalled stage");

  // a result loads only when the output register is free or being taken
  a_out_room: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_emit |-> (!out_valid || results.ready))
    else $error("output result overwritten");

  // the leaving sample never shares an entry with the one being written
  a_rd_wr_apart: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> rd_addr != wp)
    else $error("delay read and write collide");

  // fill count stays within the ram depth
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("fill count out of range");

endmodule

FILE: tb/sv/streak_window_sum_and_sinusoid_core_tb.sv
// testbench for the streak window sum and sinusoid core: directed table, then random trajectories
`timescale 1ns / 100ps

module streak_window_sum_and_sinusoid_core_tb;
  import swsc_pkg::*;

  localparam int MAX_HALF_LEN  = 63;
  localparam int SAMPLE_BITS   = 20;
  localparam int DELAY_DEPTH   = 2 * MAX_HALF_LEN + 2;
  localparam int RANDOM_ITEMS  = 850;
  localparam int SETTLE_CYCLES = 4;

  localparam logic [CFG_IDX_W-1:0]  REG_UNUSED    = 3'd7;
  localparam logic [CFG_DATA_W-1:0] Q14_ONE       = 16'h4000;
  localparam logic [CFG_DATA_W-1:0] Q14_MINUS_ONE = 16'hC000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [CFG_IDX_W-1:0]          idx;
    logic [CFG_DATA_W-1:0]         data;
    logic signed [SAMPLE_BITS-1:0] x;
    logic                          first;
    logic                          emit;
    logic                          typed;
    acc_t                          sums;
  } stim_row_t;

  localparam acc_t NO_SUMS = '0;

  // directed rows: reset defaults, then unit weights with L = 0, then negated weights
  localparam stim_row_t DIRECTED_ROWS [21] = '{
    '{ROW_ITEM, '0, '0, 20'sd0, 1'b1, 1'b1, 1'b1, NO_SUMS},
    '{ROW_ITEM, '0, '0, 20'sd16, 1'b0, 1'b1, 1'b0, NO_SUMS},
    '{ROW_ITEM, '0, '0, 20'sd524287, 1'b0, 1'b0, 1'b0, NO_SUMS},
    '{ROW_ITEM, '0, '0, -20'sd524288, 1'b0, 1'b1, 1'b0, NO_SUMS},
    '{ROW_CFG, REG_HALF_LEN, '0, '0, 1'b0, 1'b0, 1'b0, NO_SUMS},
    '{ROW_CFG, REG_COS_STEP, Q14_ONE, '0, 1'b0, 1'b0, 1'b0, NO_SUMS},
    '{ROW_CFG, REG_SIN_STEP, '0, '0, 1'b0, 1'b0, 1'b0, NO_SUMS},
    '{ROW_CFG, REG_COS_LEAD, Q14_ONE, '0, 1'b0, 1'b0, 1'b0, NO_SUMS},
    '{ROW_CFG, REG_SIN_LEAD, '0, '0, 1'b0, 1'b0, 1'b0, NO_SUMS},
    '{ROW_CFG, REG_COS_TRAIL, Q14_ONE, '0, 1'b0, 1'b0, 1'b0, NO_SUMS},
    '{ROW_CFG, REG_SIN_TRAIL, '0, '0, 1'b0, 1'b0, 1'b0, NO_SUMS},
    '{ROW_CFG, REG_UNUSED, 16'h1234, '0, 1'b0, 1'b0, 1'b0, NO_SUMS},
    '{ROW_ITEM, '0, '0, 20'sd0, 1'b1, 1'b1, 1'b1, NO_SUMS},
    '{ROW_ITEM, '0, '0, 20'sd524287, 1'b0, 1'b1, 1'b1,
      '{32'sd524287, 32'sd524287, 32'sd0}},
    '{ROW_ITEM, '0, '0, -20'sd524288, 1'b0, 1'b1, 1'b1,
      '{-32'sd524288, -32'sd524288, 32'sd0}},
    '{ROW_ITEM, '0, '0, -20'sd524288, 1'b1, 1'b0, 1'b0, NO_SUMS},
    '{ROW_ITEM, '0, '0, 20'sd1, 1'b0, 1'b1, 1'b1, '{32'sd1, 32'sd1, 32'sd0}},
    '{ROW_CFG, REG_COS_LEAD, Q14_MINUS_ONE, '0, 1'b0, 1'b0, 1'b0, NO_SUMS},
    '{ROW_CFG, REG_COS_TRAIL, Q14_MINUS_ONE, '0, 1'b0, 1'b0, 1'b0, NO_SUMS},
    '{ROW_ITEM, '0, '0, 20'sd100, 1'b1, 1'b1, 1'b1, '{32'sd100, -32'sd100, 32'sd0}},
    '{ROW_ITEM, '0, '0, -20'sd100, 1'b0, 1'b1, 1'b1, '{-32'sd100, 32'sd100, 32'sd0}}
  };

  logic clk;
  logic rst;

  swsc_cfg_if                            cfg_ch ();
  swsc_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
  swsc_out_if                            result_ch ();

  streak_window_sum_and_sinusoid_core #(
    .MAX_HALF_LEN(MAX_HALF_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .samples(sample_ch),
    .results(result_ch)
  );

  // window state mirrored from the accepted beats
  logic signed [SAMPLE_BITS-1:0] delay_line [DELAY_DEPTH];
  int unsigned                   delay_wr;
  int unsigned                   delay_fill;
  longint                        run_sum;
  longint                        run_cos;
  longint                        run_sin;
  logic [HALF_W-1:0]             half_len;
  coef_t                         weights;

  acc_t expected_sums [$];
  int   error_count;
  int   source_idle_pct;
  int   sink_idle_pct;
  logic use_typed;
  acc_t typed_sums;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[streak_window_sum_and_sinusoid_core] ERROR");
    $finish;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round half up, then drop the Q2.14 fraction
  function automatic longint round_q14(input longint v);
    return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic [COEF_W-1:0] to_q14(input real r);
    int q;
    q = $rtoi(r * 16384.0 + ((r < 0.0) ? -0.5 : 0.5));
    return q[COEF_W-1:0];
  endfunction

  // one recurrence step: enter x, drop the sample 2L+1 beats back once the fill count reaches the span
  function automatic acc_t advance_window(input logic signed [SAMPLE_BITS-1:0] x_in,
                                          input logic restart);
    int unsigned span;
    int unsigned tail_idx;
    longint      x;
    longint      y;
    longint      c0;
    longint      s0;
    longint      cs;
    longint      ss;
    longint      cl;
    longint      sl;
    longint      ct;
    longint      st;
    acc_t        sums;
    span = (half_len > MAX_HALF_LEN) ? 2 * MAX_HALF_LEN + 1 : 2 * int'(half_len) + 1;
    x  = longint'(x_in);
    cs = longint'(weights.cos_step);
    ss = longint'(weights.sin_step);
    cl = longint'(weights.cos_lead);
    sl = longint'(weights.sin_lead);
    ct = longint'(weights.cos_trail);
    st = longint'(weights.sin_trail);
    if (restart) begin
      run_sum = 0;
      run_cos = 0;
      run_sin = 0;
      delay_fill = 0;
    end
    y = 0;
    if (delay_fill >= span) begin
      tail_idx = (delay_wr + DELAY_DEPTH - span) % DELAY_DEPTH;
      y = longint'(delay_line[tail_idx]);
    end
    c0 = run_cos;
    s0 = run_sin;
    run_sum = clamp32(run_sum + x - y);
    run_cos = clamp32(round_q14(c0 * cs + s0 * ss + x * cl - y * ct));
    run_sin = clamp32(round_q14(s0 * cs - c0 * ss + x * sl + y * st));
    delay_line[delay_wr] = x_in;
    delay_wr = (delay_wr + 1) % DELAY_DEPTH;
    if (delay_fill < DELAY_DEPTH - 1) delay_fill++;
    sums.window_sum = run_sum[ACC_W-1:0];
    sums.cos_sum    = run_cos[ACC_W-1:0];
    sums.sin_sum    = run_sin[ACC_W-1:0];
    return sums;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      2, 3, 4: return SAMPLE_BITS'($urandom);
      default: return SAMPLE_BITS'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic signed [ACC_W-1:0] want,
                                      input logic signed [ACC_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // predict on every accepted sample beat
  always @(posedge clk) begin : watch_samples
    acc_t predicted;
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      predicted = advance_window(sample_ch.sample, sample_ch.first);
      if (sample_ch.emit) expected_sums.push_back(use_typed ? typed_sums : predicted);
    end
  end

  // compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin : watch_results
    acc_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_sums.size() == 0) begin
        $error("result beat with no prediction waiting");
        error_count++;
      end else begin
        want = expected_sums.pop_front();
        check_field("window_sum", want.window_sum, result_ch.window_sum);
        check_field("cos_sum", want.cos_sum, result_ch.cos_sum);
        check_field("sin_sum", want.sin_sum, result_ch.sin_sum);
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x, input logic first_flag,
                             input logic emit_flag);
    while ($urandom_range(0, 99) < source_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= x;
    sample_ch.first  <= first_flag;
    sample_ch.emit   <= emit_flag;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // register write; the mirror takes the value at the accepting edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_HALF_LEN:  half_len = value[HALF_W-1:0];
      REG_COS_STEP:  weights.cos_step = value;
      REG_SIN_STEP:  weights.sin_step = value;
      REG_COS_LEAD:  weights.cos_lead = value;
      REG_SIN_LEAD:  weights.sin_lead = value;
      REG_COS_TRAIL: weights.cos_trail = value;
      REG_SIN_TRAIL: weights.sin_trail = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // hold samples until every predicted result is out, then let the pipe settle
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    while (expected_sums.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    stim_row_t row;
    logic      items_in_flight;
    logic      cfg_open;
    int        random_items;
    int        phase;
    int        half;
    int        span;
    int        traj_len;
    int        traj_end;
    int        j;
    int        k;
    int        stretch;
    logic      continue_traj;
    logic      noisy;
    logic      first_flag;
    logic      emit_flag;
    real       w;
    coef_t     pick;
    logic [CFG_DATA_W-1:0] half_data;

    rst              = 1'b1;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    sample_ch.first  = 1'b0;
    sample_ch.emit   = 1'b0;
    result_ch.ready  = 1'b0;
    error_count      = 0;
    source_idle_pct  = 36;
    sink_idle_pct    = 81;
    use_typed        = 1'b0;
    typed_sums       = '0;

    // mirror starts from reset values
    for (j = 0; j < DELAY_DEPTH; j++) delay_line[j] = '0;
    delay_wr   = 0;
    delay_fill = 0;
    run_sum    = 0;
    run_cos    = 0;
    run_sin    = 0;
    half_len   = HALF_LEN_RST;
    weights    = '{COS_STEP_RST, SIN_STEP_RST, COS_LEAD_RST, SIN_LEAD_RST,
                   COS_TRAIL_RST, SIN_TRAIL_RST};

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed table
    items_in_flight = 1'b0;
    cfg_open        = 1'b0;
    for (j = 0; j < $size(DIRECTED_ROWS); j++) begin
      row = DIRECTED_ROWS[j];
      if (row.kind == ROW_CFG) begin
        if (items_in_flight) begin
          drain_results();
          items_in_flight = 1'b0;
        end
        write_reg(row.idx, row.data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_ch.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        use_typed  = row.typed;
        typed_sums = row.sums;
        send_sample(row.x, row.first, row.emit);
        use_typed = 1'b0;
        items_in_flight = 1'b1;
      end
    end

    // random trajectories, one weight setting per phase
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      drain_results();

      case (phase)
        0: half = MAX_HALF_LEN;
        1: half = 0;
        default: begin
          case ($urandom_range(0, 9))
            0: half = MAX_HALF_LEN;
            1: half = 0;
            2: half = $urandom_range(0, MAX_HALF_LEN);
            default: half = $urandom_range(1, 8);
          endcase
        end
      endcase
      span = 2 * half + 1;

      case ($urandom_range(0, 3))
        0, 1: begin
          // a real bin: rotation and matching lead and trail phases
          w = 6.283185307179586 * real'($urandom_range(1, 499)) / 1000.0;
          pick.cos_step  = to_q14($cos(w));
          pick.sin_step  = to_q14($sin(w));
          pick.cos_lead  = to_q14($cos(half * w));
          pick.sin_lead  = to_q14($sin(half * w));
          pick.cos_trail = to_q14($cos((half + 1) * w));
          pick.sin_trail = to_q14($sin((half + 1) * w));
        end
        2: begin
          for (k = 0; k < 6; k++)
            pick[k*COEF_W +: COEF_W] = COEF_W'(int'($urandom_range(0, 32768)) - 16384);
        end
        default: begin
          // full scale weights drive the accumulators into saturation
          for (k = 0; k < 6; k++)
            pick[k*COEF_W +: COEF_W] = COEF_W'((int'($urandom_range(0, 2)) - 1) * 16384);
        end
      endcase

      half_data = $urandom_range(0, 1) ? {10'($urandom), 6'(half)} : CFG_DATA_W'(half);
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom));
      write_reg(REG_HALF_LEN, half_data);
      write_reg(REG_COS_STEP, pick.cos_step);
      write_reg(REG_SIN_STEP, pick.sin_step);
      write_reg(REG_COS_LEAD, pick.cos_lead);
      write_reg(REG_SIN_LEAD, pick.sin_lead);
      write_reg(REG_COS_TRAIL, pick.cos_trail);
      write_reg(REG_SIN_TRAIL, pick.sin_trail);
      cfg_ch.valid <= 1'b0;

      // sometimes keep the old trajectory going across the length change
      continue_traj = (phase == 2) || ($urandom_range(0, 2) == 0);
      traj_end = random_items + 70;
      while (random_items < traj_end && random_items < RANDOM_ITEMS) begin
        traj_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, span)
                                               : span + $urandom_range(0, 40);
        noisy = ($urandom_range(0, 9) == 0);
        for (k = 0; k < traj_len; k++) begin
          first_flag = (k == 0) && !continue_traj;
          // warm-up beats only preload the window
          emit_flag = continue_traj || (k >= span - 1);
          if (noisy) begin
            first_flag = first_flag || ($urandom_range(0, 15) == 0);
            emit_flag  = 1'($urandom_range(0, 1));
          end

          stretch = random_items * 3 / RANDOM_ITEMS;
          case (stretch)
            0: begin
              source_idle_pct = 36;
              sink_idle_pct   = 81;
            end
            1: begin
              source_idle_pct = 81;
              sink_idle_pct   = 36;
            end
            default: begin
              source_idle_pct = 0;
              sink_idle_pct   = 0;
            end
          endcase

          if ($urandom_range(0, 59) == 0) drain_results();
          send_sample(random_sample(), first_flag, emit_flag);
          random_items++;
        end
        continue_traj = 1'b0;
      end
      phase++;
    end

    drain_results();
    if (error_count == 0) begin
      $display("[streak_window_sum_and_sinusoid_core] OK");
    end else begin
      $display("[streak_window_sum_and_sinusoid_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/swsc_pkg.sv
sv/swsc_in_if.sv
sv/swsc_out_if.sv
sv/swsc_cfg_if.sv
sv/swsc_ram.sv
sv/swsc_update.sv
sv/streak_window_sum_and_sinusoid_core.sv
tb/sv/streak_window_sum_and_sinusoid_core_tb.sv
